FILE: rtl/psfp_pkg.sv
// Shared types and constants for the particle sensor frame parser.
// No dependencies; compiled first.
`default_nettype none

package psfp_pkg;

  localparam int unsigned PosW   = 5;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [ByteW-1:0] HdrFirst     = 8'h43;
  localparam logic [ByteW-1:0] HdrSecond    = 8'h4D;
  localparam logic [PosW-1:0]  HdrFirstPos  = 5'd0;
  localparam logic [PosW-1:0]  HdrSecondPos = 5'd1;
  localparam logic [PosW-1:0]  PmHighPos    = 5'd6;
  localparam logic [PosW-1:0]  PmLowPos     = 5'd7;
  localparam logic [PosW-1:0]  SumSkipPos   = 5'd29;
  localparam logic [PosW-1:0]  CheckHighPos = 5'd30;
  localparam logic [PosW-1:0]  FrameLastPos = 5'd31;

  // What the back end does with one byte
  typedef enum logic [2:0] {
    OpFirst,   // header byte 0: restart sum and captures
    OpSum,     // add to sum only
    OpPmHigh,  // add to sum, capture PM2.5 high byte
    OpPmLow,   // add to sum, capture PM2.5 low byte
    OpSkip,    // byte 29: not summed
    OpChkHigh, // byte 30: checksum high byte
    OpLast     // byte 31: compare and emit result
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [ByteW-1:0] data;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

endpackage

`default_nettype wire

FILE: rtl/psfp_in_if.sv
// Input channel: one received serial byte per item.
// Depends on psfp_pkg.
`default_nettype none

interface psfp_in_if;
  logic                      valid;
  logic                      ready;
  logic [psfp_pkg::ByteW-1:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/psfp_out_if.sv
// Result channel: frame status and PM2.5 value.
// Depends on psfp_pkg.
`default_nettype none

interface psfp_out_if;
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic [psfp_pkg::WordW-1:0] pm25_value;

  modport source(output valid, output status, output pm25_value, input ready);
  modport sink(input valid, input status, input pm25_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/psfp_front.sv
// Front end: tracks frame position, checks the header, classifies bytes.
// Depends on psfp_pkg.
`default_nettype none

module psfp_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       accept_i,
  input  wire logic [psfp_pkg::ByteW-1:0] rx_byte_i,
  output psfp_pkg::push_t                 push_o
);

  logic [psfp_pkg::PosW-1:0] pos_q, pos_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (accept_i) begin
      if (pos_q == psfp_pkg::HdrFirstPos && rx_byte_i != psfp_pkg::HdrFirst) begin
        pos_d = '0;
      end else if (pos_q == psfp_pkg::HdrSecondPos && rx_byte_i != psfp_pkg::HdrSecond) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_comb begin
    push_o.push       = accept_i;
    push_o.entry.data = rx_byte_i;
    push_o.entry.op   = psfp_pkg::OpSum;
    unique case (pos_q)
      psfp_pkg::HdrFirstPos: begin
        push_o.entry.op = psfp_pkg::OpFirst;
        if (rx_byte_i != psfp_pkg::HdrFirst) push_o.push = 1'b0;
      end
      psfp_pkg::HdrSecondPos: begin
        if (rx_byte_i != psfp_pkg::HdrSecond) push_o.push = 1'b0;
      end
      psfp_pkg::PmHighPos:    push_o.entry.op = psfp_pkg::OpPmHigh;
      psfp_pkg::PmLowPos:     push_o.entry.op = psfp_pkg::OpPmLow;
      psfp_pkg::SumSkipPos:   push_o.entry.op = psfp_pkg::OpSkip;
      psfp_pkg::CheckHighPos: push_o.entry.op = psfp_pkg::OpChkHigh;
      psfp_pkg::FrameLastPos: push_o.entry.op = psfp_pkg::OpLast;
      default:                push_o.entry.op = psfp_pkg::OpSum;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/psfp_queue.sv
// Short register queue between front and back end.
// Depends on psfp_pkg.
`default_nettype none

module psfp_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  psfp_pkg::push_t push_i,
  output logic            ready_o,
  input  wire logic       pop_i,
  output logic            valid_o,
  output psfp_pkg::entry_t data_o
);

  psfp_pkg::entry_t                   mem_q [psfp_pkg::QDepth];
  logic [psfp_pkg::QPtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [psfp_pkg::QPtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [psfp_pkg::QCntW-1:0]         cnt_q, cnt_d;
  logic                               do_push, do_pop;

  assign ready_o = (cnt_q != psfp_pkg::QCntW'(psfp_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i.push && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == psfp_pkg::QPtrW'(psfp_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == psfp_pkg::QPtrW'(psfp_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/psfp_back.sv
// Back end: running sum, PM2.5 capture, checksum compare, result register.
// Depends on psfp_pkg.
`default_nettype none

module psfp_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  psfp_pkg::entry_t                 entry_i,
  output logic                             pop_o,
  output logic                             res_valid_o,
  input  wire logic                        res_ready_i,
  output logic                             status_o,
  output logic [psfp_pkg::WordW-1:0]       pm25_value_o
);

  logic [psfp_pkg::WordW-1:0] sum_q, sum_d;
  logic [psfp_pkg::WordW-1:0] pm_q, pm_d;
  logic [psfp_pkg::ByteW-1:0] chk_q, chk_d;
  logic                       res_valid_q, res_valid_d;
  logic                       status_q, status_d;
  logic [psfp_pkg::WordW-1:0] res_pm_q, res_pm_d;
  logic                       slot_free;
  logic                       is_last;
  logic [psfp_pkg::WordW-1:0] byte_ext;
  logic                       match;

  assign slot_free = !res_valid_q || res_ready_i;
  assign is_last   = (entry_i.op == psfp_pkg::OpLast);
  assign pop_o     = valid_i && (!is_last || slot_free);
  assign byte_ext  = {{(psfp_pkg::WordW - psfp_pkg::ByteW){1'b0}}, entry_i.data};
  assign match     = ({chk_q, entry_i.data} == sum_q);

  always_comb begin
    sum_d       = sum_q;
    pm_d        = pm_q;
    chk_d       = chk_q;
    res_valid_d = res_valid_q && !res_ready_i;
    status_d    = status_q;
    res_pm_d    = res_pm_q;
    if (pop_o) begin
      unique case (entry_i.op)
        psfp_pkg::OpFirst: begin
          sum_d = byte_ext;
          pm_d  = '0;
          chk_d = '0;
        end
        psfp_pkg::OpSum:    sum_d = sum_q + byte_ext;
        psfp_pkg::OpPmHigh: begin
          sum_d = sum_q + byte_ext;
          pm_d  = {entry_i.data, pm_q[psfp_pkg::ByteW-1:0]};
        end
        psfp_pkg::OpPmLow: begin
          sum_d = sum_q + byte_ext;
          pm_d  = {pm_q[psfp_pkg::WordW-1:psfp_pkg::ByteW], entry_i.data};
        end
        psfp_pkg::OpSkip:    ;
        psfp_pkg::OpChkHigh: chk_d = entry_i.data;
        psfp_pkg::OpLast: begin
          res_valid_d = 1'b1;
          status_d    = !match;
          res_pm_d    = match ? pm_q : '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      pm_q        <= '0;
      chk_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      pm_q        <= pm_d;
      chk_q       <= chk_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    res_pm_q <= res_pm_d;
  end

  assign res_valid_o  = res_valid_q;
  assign status_o     = status_q;
  assign pm25_value_o = res_pm_q;

endmodule

`default_nettype wire

FILE: rtl/particle_sensor_frame_parser_core.sv
// Top level of the particle sensor frame parser.
// Depends on psfp_pkg, psfp_in_if, psfp_out_if, psfp_front, psfp_queue, psfp_back.
//
// Usage:
//   rx_i carries one received serial byte per item (valid/ready). Bytes are
//   assembled into 32-byte frames starting 0x43 0x4D; a bad header byte is
//   dropped and the parser looks for byte 0 again.
//   res_o gives one item per complete frame: status 0 when the 16-bit sum of
//   bytes 0..28 equals bytes 30..31 (big-endian) with the PM2.5 value from
//   bytes 6..7, else status 1 with a zero value.
//   Throughput: one byte per cycle. The front end classifies a byte in the
//   cycle it is taken, a two-entry queue passes it to the back end, which
//   updates the sum and loads the result register.
//   Byte 31 passes through the queue into the back end, which sets the result valid.
//   Stall: while a result waits in the output register, non-final bytes
//   keep flowing; the next final byte waits in the queue, and rx_i.ready
//   drops once the queue is full.
//   Reset: asynchronous, active low; clears position, sum, captures, queue
//   and the result valid.
`default_nettype none

module particle_sensor_frame_parser_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  psfp_in_if.sink     rx_i,
  psfp_out_if.source  res_o
);

  psfp_pkg::push_t  push;
  psfp_pkg::entry_t q_data;
  logic             q_ready, q_valid, q_pop;
  logic             accept;

  assign rx_i.ready = q_ready;
  assign accept     = rx_i.valid && q_ready;

  psfp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_i.rx_byte),
    .push_o    (push)
  );

  psfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  psfp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .entry_i      (q_data),
    .pop_o        (q_pop),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .status_o     (res_o.status),
    .pm25_value_o (res_o.pm25_value)
  );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for particle_sensor_frame_parser_core: serial bytes in, frame results out.
// Predicts each frame result in step with accepted bytes and checks results in order.
// Depends on psfp_pkg, psfp_in_if, psfp_out_if and the parser RTL.
`timescale 1ns / 100ps

module tb;

  localparam int  RandomItems = 1050;
  localparam int  CycleLimit  = 100000;
  localparam int  DrainCycles = 10;
  localparam logic StatusOk     = 1'b0;
  localparam logic StatusBadSum = 1'b1;

  typedef struct {
    logic                       status;
    logic [psfp_pkg::WordW-1:0] pm25;
  } frame_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  psfp_in_if  rx_if();
  psfp_out_if res_if();

  particle_sensor_frame_parser_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [psfp_pkg::ByteW-1:0] rx_bytes_q[$];
  frame_result_t              pending_results[$];
  int n_items        = 0;
  int bytes_sent     = 0;
  int bytes_accepted = 0;
  int mismatches     = 0;
  int cycles         = 0;

  // parser state as predicted
  logic [psfp_pkg::PosW-1:0]  fp_pos;
  logic [psfp_pkg::WordW-1:0] fp_sum;
  logic [psfp_pkg::WordW-1:0] fp_pm;
  logic [psfp_pkg::ByteW-1:0] fp_chk;

  function automatic void frame_restart();
    fp_pos = '0;
    fp_sum = '0;
    fp_pm  = '0;
    fp_chk = '0;
  endfunction

  function automatic void frame_track(input logic [psfp_pkg::ByteW-1:0] b);
    frame_result_t r;
    logic ok;
    if ((fp_pos == psfp_pkg::HdrFirstPos && b != psfp_pkg::HdrFirst) ||
        (fp_pos == psfp_pkg::HdrSecondPos && b != psfp_pkg::HdrSecond)) begin
      frame_restart();
      return;
    end
    if (fp_pos < psfp_pkg::SumSkipPos) fp_sum = fp_sum + psfp_pkg::WordW'(b);
    if (fp_pos == psfp_pkg::PmHighPos) fp_pm[15:8] = b;
    if (fp_pos == psfp_pkg::PmLowPos) fp_pm[7:0] = b;
    if (fp_pos == psfp_pkg::CheckHighPos) fp_chk = b;
    if (fp_pos == psfp_pkg::FrameLastPos) begin
      ok = ({fp_chk, b} == fp_sum);
      r.status = ok ? StatusOk : StatusBadSum;
      r.pm25   = ok ? fp_pm : '0;
      pending_results.push_back(r);
      frame_restart();
    end else begin
      fp_pos = fp_pos + 1'b1;
    end
  endfunction

  // fill < 0 gives random content bytes
  task automatic add_frame(input logic [psfp_pkg::WordW-1:0] pm, input bit good_sum,
                           input int len, input int fill);
    logic [psfp_pkg::ByteW-1:0] fr[32];
    logic [psfp_pkg::WordW-1:0] sum;
    logic [psfp_pkg::WordW-1:0] flip;
    int i;
    fr[0] = psfp_pkg::HdrFirst;
    fr[1] = psfp_pkg::HdrSecond;
    for (i = 2; i < 30; i++)
      fr[i] = (fill < 0) ? psfp_pkg::ByteW'($urandom) : psfp_pkg::ByteW'(fill);
    fr[psfp_pkg::PmHighPos] = pm[15:8];
    fr[psfp_pkg::PmLowPos]  = pm[7:0];
    sum = '0;
    for (i = 0; i < psfp_pkg::SumSkipPos; i++) sum = sum + psfp_pkg::WordW'(fr[i]);
    flip = good_sum ? '0 : psfp_pkg::WordW'($urandom_range(1, 65535));
    {fr[30], fr[31]} = sum ^ flip;
    for (i = 0; i < len; i++) rx_bytes_q.push_back(fr[i]);
  endtask

  function automatic logic [psfp_pkg::WordW-1:0] pick_pm();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return psfp_pkg::WordW'($urandom);
    endcase
  endfunction

  function automatic int tx_idle_pct();
    if (bytes_sent < n_items / 3) return 17;
    if (bytes_sent < 2 * n_items / 3) return 67;
    return 0;
  endfunction

  function automatic int rx_idle_pct();
    if (bytes_sent < n_items / 3) return 67;
    if (bytes_sent < 2 * n_items / 3) return 17;
    return 0;
  endfunction

  // stimulus
  initial begin
    int kind;
    logic [psfp_pkg::ByteW-1:0] b;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    res_if.ready   = 1'b0;
    frame_restart();

    // header breaks: bad first byte, bad second byte not retried as a header
    rx_bytes_q.push_back(8'h00);
    rx_bytes_q.push_back(8'hFF);
    rx_bytes_q.push_back(psfp_pkg::HdrSecond);
    rx_bytes_q.push_back(psfp_pkg::HdrFirst);
    rx_bytes_q.push_back(psfp_pkg::HdrFirst);
    rx_bytes_q.push_back(psfp_pkg::HdrSecond);
    rx_bytes_q.push_back(psfp_pkg::HdrFirst);
    rx_bytes_q.push_back(8'hFF);
    add_frame('0, 1'b1, 32, 0);
    add_frame('1, 1'b1, 32, 255);
    add_frame('1, 1'b0, 32, -1);
    add_frame(16'h1234, 1'b1, 32, -1);

    while (rx_bytes_q.size() < RandomItems) begin
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        repeat ($urandom_range(1, 6)) rx_bytes_q.push_back(psfp_pkg::ByteW'($urandom));
      end else if (kind == 2) begin
        b = psfp_pkg::ByteW'($urandom);
        if (b == psfp_pkg::HdrSecond) b = ~b;
        rx_bytes_q.push_back(psfp_pkg::HdrFirst);
        rx_bytes_q.push_back(b);
      end else if (kind == 3) begin
        add_frame(pick_pm(), 1'b1, $urandom_range(2, 31), -1);
      end else begin
        add_frame(pick_pm(), $urandom_range(0, 2) != 0, 32, -1);
      end
    end
    n_items = rx_bytes_q.size();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (bytes_accepted == n_items && pending_results.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= '0;
    end else if (!rx_if.valid || rx_if.ready) begin
      if (rx_bytes_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct()) begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= rx_bytes_q.pop_front();
        bytes_sent++;
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct());
    end
  end

  // monitor: predict on accepted bytes, check accepted results
  always @(posedge clk_i) begin
    frame_result_t exp_r;
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        bytes_accepted++;
        frame_track(rx_if.rx_byte);
      end
      if (res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0b pm25 %h", res_if.status, res_if.pm25_value);
        end else begin
          exp_r = pending_results.pop_front();
          if (res_if.status !== exp_r.status || res_if.pm25_value !== exp_r.pm25) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: exp status %0b pm25 %h, got status %0b pm25 %h",
                       exp_r.status, exp_r.pm25, res_if.status, res_if.pm25_value);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
